// File: sv/lstm_cell_update_defines.svh
// ----------------------------------------------------------------------------
// lstm_cell_update_defines.svh
// Assertion macros shared by the LSTM cell update RTL.
// ----------------------------------------------------------------------------
`ifndef LSTM_CELL_UPDATE_DEFINES_SVH
`define LSTM_CELL_UPDATE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define LCU_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Same-cycle implication.
`define LCU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LCU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/lcu_pkg.sv
// ----------------------------------------------------------------------------
// lcu_pkg
// Widths, queue entry type, activation table and rounding helpers for the
// LSTM cell update block.
// ----------------------------------------------------------------------------
package lcu_pkg;

    localparam int DATA_W            = 16;
    localparam int FRAC_BITS         = 12;
    localparam int ACT_TABLE_ENTRIES = 256;

    localparam int ONE        = 1 << FRAC_BITS;
    localparam int HALF       = 1 << (FRAC_BITS - 1);
    localparam int TAB_W      = FRAC_BITS + 1;
    localparam int IDX_W      = $clog2(ACT_TABLE_ENTRIES);
    localparam int ACT_W      = TAB_W + 1;
    localparam int SHIFT_TANH = DATA_W - 1;
    localparam int SHIFT_SIGM = DATA_W;
    localparam int FRAC_W     = SHIFT_SIGM;
    localparam int P_W        = DATA_W + $clog2(ACT_TABLE_ENTRIES) + 1;
    localparam int PROD_W     = ACT_W + FRAC_W + 1;
    localparam int MUL_W      = ACT_W + DATA_W;
    localparam int SUM_W      = MUL_W + 1;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    // Registered steps in the back end before the output register.
    localparam int BACK_STAGES = 9;
    localparam int GATE_STAGE  = 2;
    localparam int TANH_STAGE  = 7;

    localparam logic signed [ACT_W-1:0] ACT_ONE = ACT_W'(ONE);

    typedef struct packed {
        logic signed [DATA_W-1:0] gate_i;
        logic signed [DATA_W-1:0] gate_o;
        logic signed [DATA_W-1:0] gate_f;
        logic signed [DATA_W-1:0] gate_g;
        logic signed [DATA_W-1:0] cell_prev;
    } lcu_entry_t;

    typedef logic [TAB_W-1:0] tab_t [ACT_TABLE_ENTRIES];

    // One tanh table entry, built in Q30 integer arithmetic: a truncated
    // series for e^-z, twelve squarings, then a rounded long division.
    function automatic logic [TAB_W-1:0] tanh_entry(input int unsigned k);
        logic [63:0] one_q;
        logic [63:0] z;
        logic [63:0] t;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] v;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] rem;
        logic [63:0] quo;
        int i;
        one_q = 64'd1 << 30;
        z = ((64'(k) << (34 - FRAC_BITS)) + 64'(ACT_TABLE_ENTRIES / 2))
            / 64'(ACT_TABLE_ENTRIES);
        pos = one_q;
        neg = 64'd0;
        t = one_q;
        t = (t * z) >> 30;
        neg = neg + t;
        t = ((t * z) >> 30) / 2;
        pos = pos + t;
        t = ((t * z) >> 30) / 3;
        neg = neg + t;
        t = ((t * z) >> 30) / 4;
        pos = pos + t;
        t = ((t * z) >> 30) / 5;
        neg = neg + t;
        t = ((t * z) >> 30) / 6;
        pos = pos + t;
        v = (pos > neg) ? (pos - neg) : 64'd0;
        for (i = 0; i < 12; i++)
        begin
            v = (v * v + (64'd1 << 29)) >> 30;
        end
        den = one_q + v;
        num = ((one_q - v) << FRAC_BITS) + (den >> 1);
        rem = 64'd0;
        quo = 64'd0;
        for (i = 47; i >= 0; i--)
        begin
            rem = (rem << 1) | 64'(num[i]);
            if (rem >= den)
            begin
                rem = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo[TAB_W-1:0];
    endfunction

    function automatic tab_t build_tab();
        tab_t tab;
        int k;
        for (k = 0; k < ACT_TABLE_ENTRIES; k++)
        begin
            tab[k] = tanh_entry(k);
        end
        return tab;
    endfunction

    localparam tab_t             TANH_TAB = build_tab();
    localparam logic [TAB_W-1:0] TANH_TOP = tanh_entry(ACT_TABLE_ENTRIES);

    // Add two Q values, clamp to the 16-bit range.
    function automatic logic signed [DATA_W-1:0] sat_add(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] s;
        s = $signed({a[DATA_W-1], a}) + $signed({b[DATA_W-1], b});
        if (s[DATA_W] != s[DATA_W-1])
        begin
            return s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return s[DATA_W-1:0];
    endfunction

    // Round half up by FRAC_BITS, then clamp to the 16-bit range.
    function automatic logic signed [DATA_W-1:0] round_sat(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SUM_W:0] r;
        logic signed [SUM_W:0] sh;
        r = $signed({v[SUM_W-1], v}) + $signed((SUM_W+1)'(HALF));
        sh = r >>> FRAC_BITS;
        if (sh[SUM_W:DATA_W-1] != {(SUM_W-DATA_W+2){sh[SUM_W]}})
        begin
            return sh[SUM_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return sh[DATA_W-1:0];
    endfunction

endpackage

// File: sv/lcu_front.sv
// ----------------------------------------------------------------------------
// lcu_front
// Accepts requests, forms the saturated gate sums and holds them in a short
// queue for the back end.
// ----------------------------------------------------------------------------
`include "lstm_cell_update_defines.svh"

module lcu_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [lcu_pkg::DATA_W-1:0]   pre_input_gate,
    input  logic signed [lcu_pkg::DATA_W-1:0]   pre_output_gate,
    input  logic signed [lcu_pkg::DATA_W-1:0]   pre_forget_gate,
    input  logic signed [lcu_pkg::DATA_W-1:0]   pre_candidate,
    input  logic signed [lcu_pkg::DATA_W-1:0]   bias_input_gate,
    input  logic signed [lcu_pkg::DATA_W-1:0]   bias_output_gate,
    input  logic signed [lcu_pkg::DATA_W-1:0]   bias_forget_gate,
    input  logic signed [lcu_pkg::DATA_W-1:0]   bias_candidate,
    input  logic signed [lcu_pkg::DATA_W-1:0]   cell_prev,
    output logic                                q_valid,
    output lcu_pkg::lcu_entry_t                 q_head,
    input  logic                                pop
);

    lcu_pkg::lcu_entry_t             mem_reg [lcu_pkg::Q_DEPTH];
    lcu_pkg::lcu_entry_t             entry;
    logic [lcu_pkg::Q_PTR_W-1:0]     wr_ptr_reg;
    logic [lcu_pkg::Q_PTR_W-1:0]     wr_ptr_next;
    logic [lcu_pkg::Q_PTR_W-1:0]     rd_ptr_reg;
    logic [lcu_pkg::Q_PTR_W-1:0]     rd_ptr_next;
    logic [lcu_pkg::Q_CNT_W-1:0]     count_reg;
    logic [lcu_pkg::Q_CNT_W-1:0]     count_next;
    logic                            push;

    always_comb
    begin
        entry.gate_i    = lcu_pkg::sat_add(pre_input_gate, bias_input_gate);
        entry.gate_o    = lcu_pkg::sat_add(pre_output_gate, bias_output_gate);
        entry.gate_f    = lcu_pkg::sat_add(pre_forget_gate, bias_forget_gate);
        entry.gate_g    = lcu_pkg::sat_add(pre_candidate, bias_candidate);
        entry.cell_prev = cell_prev;
    end

    assign in_ready = (count_reg != lcu_pkg::Q_CNT_W'(lcu_pkg::Q_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign q_head   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= entry;
        end
    end

    `LCU_ASSERT_ALWAYS(a_q_count_max, clk, rst_n, count_reg <= lcu_pkg::Q_CNT_W'(lcu_pkg::Q_DEPTH), "queue count above depth")
    `LCU_ASSERT_IMPL(a_q_pop_nonempty, clk, rst_n, pop, count_reg != '0, "pop from empty queue")
    `LCU_ASSERT_NEXT(a_q_push_count, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count did not grow on push")

endmodule

// File: sv/lcu_act.sv
// ----------------------------------------------------------------------------
// lcu_act
// Three-stage tanh/sigmoid unit: table read, slope times fraction, then
// interpolation with sign and sigmoid scaling.
// ----------------------------------------------------------------------------
module lcu_act (
    input  logic                               clk,
    input  logic                               en,
    input  logic                               sigm,
    input  logic signed [lcu_pkg::DATA_W-1:0]  x,
    output logic signed [lcu_pkg::ACT_W-1:0]   y
);

    logic [lcu_pkg::DATA_W-1:0]        mag;
    logic [lcu_pkg::P_W-1:0]           p;
    logic [lcu_pkg::P_W-1:0]           k;
    logic                              top;
    logic [lcu_pkg::IDX_W-1:0]         idx;
    logic [lcu_pkg::IDX_W-1:0]         idx1;
    logic [lcu_pkg::TAB_W-1:0]         hi;
    logic [lcu_pkg::TAB_W-1:0]         lo_next;
    logic signed [lcu_pkg::ACT_W-1:0]  d_next;
    logic [lcu_pkg::FRAC_W-1:0]        frac_next;

    logic [lcu_pkg::TAB_W-1:0]         lo_reg;
    logic signed [lcu_pkg::ACT_W-1:0]  d_reg;
    logic [lcu_pkg::FRAC_W-1:0]        frac_reg;
    logic                              neg_reg;

    logic signed [lcu_pkg::PROD_W-1:0] prod_next;
    logic signed [lcu_pkg::PROD_W-1:0] prod_reg;
    logic [lcu_pkg::TAB_W-1:0]         lo2_reg;
    logic                              neg2_reg;

    logic [lcu_pkg::PROD_W:0]          half;
    logic signed [lcu_pkg::PROD_W:0]   r;
    logic signed [lcu_pkg::PROD_W:0]   rs;
    logic signed [lcu_pkg::ACT_W-1:0]  m;
    logic signed [lcu_pkg::ACT_W-1:0]  t;
    logic signed [lcu_pkg::ACT_W:0]    sg;
    logic signed [lcu_pkg::ACT_W-1:0]  y_next;
    logic signed [lcu_pkg::ACT_W-1:0]  y_reg;

    // Stage 1: magnitude, table position and the two neighboring entries.
    // The sigmoid reads tanh(x/2), which is the same table at half the step.
    always_comb
    begin
        mag = x[lcu_pkg::DATA_W-1] ? lcu_pkg::DATA_W'(-x) : lcu_pkg::DATA_W'(x);
        p   = lcu_pkg::P_W'(mag) * lcu_pkg::P_W'(lcu_pkg::ACT_TABLE_ENTRIES);
        k   = sigm ? (p >> lcu_pkg::SHIFT_SIGM) : (p >> lcu_pkg::SHIFT_TANH);
        top = (k >= lcu_pkg::P_W'(lcu_pkg::ACT_TABLE_ENTRIES));
        idx = k[lcu_pkg::IDX_W-1:0];
        idx1 = (idx == lcu_pkg::IDX_W'(lcu_pkg::ACT_TABLE_ENTRIES - 1)) ? '0 : idx + 1'b1;
        hi = (idx == lcu_pkg::IDX_W'(lcu_pkg::ACT_TABLE_ENTRIES - 1))
            ? lcu_pkg::TANH_TOP : lcu_pkg::TANH_TAB[idx1];
        lo_next = lcu_pkg::TANH_TAB[idx];
        if (top)
        begin
            lo_next = lcu_pkg::TANH_TOP;
            hi      = lcu_pkg::TANH_TOP;
        end
        d_next    = $signed({1'b0, hi}) - $signed({1'b0, lo_next});
        frac_next = sigm ? p[lcu_pkg::FRAC_W-1:0]
                         : {1'b0, p[lcu_pkg::SHIFT_TANH-1:0]};
    end

    // Stage 2: slope times fraction.
    assign prod_next = lcu_pkg::PROD_W'(d_reg)
                     * lcu_pkg::PROD_W'($signed({1'b0, frac_reg}));

    // Stage 3: round half up, add the lower entry, restore the sign; for the sigmoid, map t to (t + 1) / 2.
    always_comb
    begin
        half = sigm ? (lcu_pkg::PROD_W+1)'(1) << (lcu_pkg::SHIFT_SIGM - 1)
                    : (lcu_pkg::PROD_W+1)'(1) << (lcu_pkg::SHIFT_TANH - 1);
        r    = $signed({prod_reg[lcu_pkg::PROD_W-1], prod_reg}) + $signed(half);
        rs   = sigm ? (r >>> lcu_pkg::SHIFT_SIGM) : (r >>> lcu_pkg::SHIFT_TANH);
        m    = $signed({1'b0, lo2_reg}) + $signed(rs[lcu_pkg::ACT_W-1:0]);
        t    = neg2_reg ? -m : m;
        sg   = ($signed({t[lcu_pkg::ACT_W-1], t})
               + $signed((lcu_pkg::ACT_W+1)'(lcu_pkg::ONE + 1))) >>> 1;
        y_next = sigm ? sg[lcu_pkg::ACT_W-1:0] : t;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg   <= lo_next;
            d_reg    <= d_next;
            frac_reg <= frac_next;
            neg_reg  <= x[lcu_pkg::DATA_W-1];
            prod_reg <= prod_next;
            lo2_reg  <= lo_reg;
            neg2_reg <= neg_reg;
            y_reg    <= y_next;
        end
    end

    assign y = y_reg;

endmodule

// File: sv/lcu_back.sv
// ----------------------------------------------------------------------------
// lcu_back
// Gate activations, cell update, tanh of the new cell and hidden product,
// as one pipeline that advances whenever the output register can move.
// ----------------------------------------------------------------------------
`include "lstm_cell_update_defines.svh"

module lcu_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    input  lcu_pkg::lcu_entry_t                q_head,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [lcu_pkg::DATA_W-1:0]  cell_next,
    output logic signed [lcu_pkg::DATA_W-1:0]  hidden_next
);

    logic                               adv;
    logic [lcu_pkg::BACK_STAGES-1:0]    v_reg;
    logic [lcu_pkg::BACK_STAGES-1:0]    v_next;
    logic                               out_valid_reg;

    logic signed [lcu_pkg::ACT_W-1:0]   gi;
    logic signed [lcu_pkg::ACT_W-1:0]   go;
    logic signed [lcu_pkg::ACT_W-1:0]   gf;
    logic signed [lcu_pkg::ACT_W-1:0]   gg;
    logic signed [lcu_pkg::ACT_W-1:0]   tc;

    logic signed [lcu_pkg::DATA_W-1:0]  cp_d_reg [3];
    logic signed [lcu_pkg::MUL_W-1:0]   mf_reg;
    logic signed [lcu_pkg::MUL_W-1:0]   mi_reg;
    logic signed [lcu_pkg::ACT_W-1:0]   go_e_reg;
    logic signed [lcu_pkg::DATA_W-1:0]  cell_f_reg;
    logic signed [lcu_pkg::DATA_W-1:0]  cell_f_next;
    logic signed [lcu_pkg::ACT_W-1:0]   go_f_reg;
    logic signed [lcu_pkg::ACT_W-1:0]   go_t_reg [3];
    logic signed [lcu_pkg::DATA_W-1:0]  cell_t_reg [3];
    logic signed [lcu_pkg::MUL_W-1:0]   mh_reg;
    logic signed [lcu_pkg::DATA_W-1:0]  cell_j_reg;
    logic signed [lcu_pkg::DATA_W-1:0]  cell_out_reg;
    logic signed [lcu_pkg::DATA_W-1:0]  hid_out_reg;

    // Every stage moves together; a stalled output freezes the whole line.
    assign adv = !out_valid_reg || out_ready;
    assign pop = adv && q_valid;

    lcu_act u_act_i (.clk(clk), .en(adv), .sigm(1'b1), .x(q_head.gate_i), .y(gi));
    lcu_act u_act_o (.clk(clk), .en(adv), .sigm(1'b1), .x(q_head.gate_o), .y(go));
    lcu_act u_act_f (.clk(clk), .en(adv), .sigm(1'b1), .x(q_head.gate_f), .y(gf));
    lcu_act u_act_g (.clk(clk), .en(adv), .sigm(1'b0), .x(q_head.gate_g), .y(gg));
    lcu_act u_act_c (.clk(clk), .en(adv), .sigm(1'b0), .x(cell_f_reg), .y(tc));

    assign v_next      = {v_reg[lcu_pkg::BACK_STAGES-2:0], q_valid};
    assign cell_f_next = lcu_pkg::round_sat(lcu_pkg::SUM_W'(mf_reg)
                                            + lcu_pkg::SUM_W'(mi_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg         <= v_next;
            out_valid_reg <= v_reg[lcu_pkg::BACK_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cp_d_reg[0]   <= q_head.cell_prev;
            cp_d_reg[1]   <= cp_d_reg[0];
            cp_d_reg[2]   <= cp_d_reg[1];
            mf_reg        <= lcu_pkg::MUL_W'(gf) * lcu_pkg::MUL_W'(cp_d_reg[2]);
            mi_reg        <= lcu_pkg::MUL_W'(gi) * lcu_pkg::MUL_W'(gg);
            go_e_reg      <= go;
            cell_f_reg    <= cell_f_next;
            go_f_reg      <= go_e_reg;
            go_t_reg[0]   <= go_f_reg;
            go_t_reg[1]   <= go_t_reg[0];
            go_t_reg[2]   <= go_t_reg[1];
            cell_t_reg[0] <= cell_f_reg;
            cell_t_reg[1] <= cell_t_reg[0];
            cell_t_reg[2] <= cell_t_reg[1];
            mh_reg        <= lcu_pkg::MUL_W'(go_t_reg[2]) * lcu_pkg::MUL_W'(tc);
            cell_j_reg    <= cell_t_reg[2];
            cell_out_reg  <= cell_j_reg;
            hid_out_reg   <= lcu_pkg::round_sat(lcu_pkg::SUM_W'(mh_reg));
        end
    end

    assign out_valid   = out_valid_reg;
    assign cell_next   = cell_out_reg;
    assign hidden_next = hid_out_reg;

    `LCU_ASSERT_IMPL(a_gate_i_range, clk, rst_n, v_reg[lcu_pkg::GATE_STAGE], (gi >= 0) && (gi <= lcu_pkg::ACT_ONE), "input gate outside sigmoid range")
    `LCU_ASSERT_IMPL(a_tanh_range, clk, rst_n, v_reg[lcu_pkg::TANH_STAGE], (tc >= -lcu_pkg::ACT_ONE) && (tc <= lcu_pkg::ACT_ONE), "tanh of cell outside range")

endmodule

// File: sv/lstm_cell_update.sv
// ----------------------------------------------------------------------------
// lstm_cell_update
// Elementwise LSTM cell for one hidden neuron, signed Q3.12 throughout.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one neuron per request: four
//   gate pre-activations, their summed biases and the previous cell value.
//   Output channel (out_valid/out_ready) returns cell_next = f*c + i*g and
//   hidden_next = o*tanh(cell_next), both rounded and saturated.
//   A request is written to the input queue at the accepting edge and is
//   popped from it, once the back end advances and it heads the queue,
//   into the first of nine pipeline steps (three for the table
//   activations, two for the cell update, three for tanh of the cell, one
//   for the hidden product); the output register follows. Throughput is
//   one request per cycle while the output is not stalled, set by the
//   fully pipelined activation units.
//   When out_ready is low while out_valid is high, the back pipeline freezes and
//   the four-entry input queue keeps accepting; in_ready drops once it fills.
//   Reset empties the queue and clears every pipeline valid bit; no clearing
//   pass is needed and the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module lstm_cell_update (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [lcu_pkg::DATA_W-1:0]  pre_input_gate,
    input  logic signed [lcu_pkg::DATA_W-1:0]  pre_output_gate,
    input  logic signed [lcu_pkg::DATA_W-1:0]  pre_forget_gate,
    input  logic signed [lcu_pkg::DATA_W-1:0]  pre_candidate,
    input  logic signed [lcu_pkg::DATA_W-1:0]  bias_input_gate,
    input  logic signed [lcu_pkg::DATA_W-1:0]  bias_output_gate,
    input  logic signed [lcu_pkg::DATA_W-1:0]  bias_forget_gate,
    input  logic signed [lcu_pkg::DATA_W-1:0]  bias_candidate,
    input  logic signed [lcu_pkg::DATA_W-1:0]  cell_prev,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [lcu_pkg::DATA_W-1:0]  cell_next,
    output logic signed [lcu_pkg::DATA_W-1:0]  hidden_next
);

    logic                 q_valid;
    lcu_pkg::lcu_entry_t  q_head;
    logic                 pop;

    lcu_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .pre_input_gate   (pre_input_gate),
        .pre_output_gate  (pre_output_gate),
        .pre_forget_gate  (pre_forget_gate),
        .pre_candidate    (pre_candidate),
        .bias_input_gate  (bias_input_gate),
        .bias_output_gate (bias_output_gate),
        .bias_forget_gate (bias_forget_gate),
        .bias_candidate   (bias_candidate),
        .cell_prev        (cell_prev),
        .q_valid          (q_valid),
        .q_head           (q_head),
        .pop              (pop)
    );

    lcu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cell_next   (cell_next),
        .hidden_next (hidden_next)
    );

endmodule
